// ===== hw/rtl/abst_pkg.sv =====
// Package for the array binary search tree insert unit.
// Holds the beat types, status codes and default sizes; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package abst_pkg;

  localparam int TABLE_SIZE_DEF = 512;
  localparam int KEY_WIDTH_DEF  = 32;
  localparam int KEY_IN_WIDTH   = 32;
  localparam int SLOT_WIDTH     = 9;
  localparam int STATUS_WIDTH   = 2;
  // Generation tag kept next to each key; tag zero never marks a live tree.
  localparam int EPOCH_WIDTH    = 4;

  localparam logic [STATUS_WIDTH-1:0] ST_ROOT      = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_INSERTED  = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_OVERFLOW  = 2'd3;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic                           op;
    logic signed [KEY_IN_WIDTH-1:0] key;
  } abst_in_t;

  typedef struct packed {
    logic [STATUS_WIDTH-1:0] status;
    logic [SLOT_WIDTH-1:0]   slot;
  } abst_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/array_bst_insert_dedup_unit.sv =====
// Array binary search tree insert unit: top level, built around one abst_ram instance.
// Depends on abst_pkg and abst_ram.
// An insert walks the tree with one RAM read per level, and its result strobes in the cycle
// after the last walk state; busy is low again then.
// A start strobes its result in the cycle after acceptance, except every (2**EPOCH_WIDTH-1)-th
// start, which first sweeps all TABLE_SIZE slots before the result.
// Reset: synchronous; a clearing pass over all TABLE_SIZE slots with busy high. No back-pressure.
`timescale 1ns / 1ps
`default_nettype none

module array_bst_insert_dedup_unit
  import abst_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire abst_in_t  cmd,
  output logic           done,
  output abst_out_t      result
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int MW = KEY_WIDTH + EPOCH_WIDTH;

  // Controller states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_CLEAR = 2'd2;
  localparam logic [1:0] S_ROOT  = 2'd3;

  localparam logic [EPOCH_WIDTH-1:0] EPOCH_FIRST = EPOCH_WIDTH'(1);
  localparam logic [EPOCH_WIDTH-1:0] EPOCH_LAST  = {EPOCH_WIDTH{1'b1}};
  localparam logic [EPOCH_WIDTH-1:0] EPOCH_DEAD  = '0;

  // Registers.
  logic [1:0]                   state;
  logic [AW-1:0]                cur;
  logic [AW-1:0]                clr_cnt;
  logic                         clr_root;
  logic [EPOCH_WIDTH-1:0]       epoch;
  logic signed [KEY_WIDTH-1:0]  key_q;

  // RAM ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [MW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [MW-1:0] ram_rdata;

  // Each slot holds its key and the generation tag of the tree that wrote it. A slot is
  // occupied only when its tag equals the current generation, so a start simply bumps the
  // generation instead of clearing every occupied bit. Once the tag space is used up the
  // unit sweeps the whole table back to the dead tag and starts over at the first one.
  logic                        accept;
  logic signed [KEY_WIDTH-1:0] key_in;
  logic [EPOCH_WIDTH-1:0]      rd_tag;
  logic signed [KEY_WIDTH-1:0] rd_key;
  logic                        rd_live;
  logic                        rd_equal;
  logic                        rd_less;
  logic [AW+1:0]               child;
  logic                        child_out;
  logic [AW+SLOT_WIDTH-1:0]    cur_wide;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  // Keys narrower than the input are truncated; wider ones are sign-extended.
  assign key_in   = KEY_WIDTH'(cmd.key);
  assign rd_tag   = ram_rdata[MW-1:KEY_WIDTH];
  assign rd_key   = ram_rdata[KEY_WIDTH-1:0];
  assign rd_live  = (rd_tag == epoch);
  assign rd_equal = (rd_key == key_q);
  assign rd_less  = (key_q < rd_key);
  // Left child at 2*cur+1 for smaller keys, right child at 2*cur+2 for larger ones.
  assign child     = {1'b0, cur, 1'b0} + (rd_less ? (AW+2)'(1) : (AW+2)'(2));
  assign child_out = (child >= (AW+2)'(TABLE_SIZE));
  assign cur_wide  = (AW+SLOT_WIDTH)'(cur);

  // The read address is steered combinationally: slot zero when an item is taken, the
  // next child while walking.
  always_comb begin
    ram_raddr = '0;
    if (state == S_WALK) begin
      ram_raddr = child[AW-1:0];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = {epoch, key_q};
    case (state)
      S_IDLE: begin
        // A start that does not exhaust the tags writes the new root at once.
        if (accept && (cmd.op == OP_START) && (epoch != EPOCH_LAST)) begin
          ram_we    = 1'b1;
          ram_wdata = {epoch + EPOCH_FIRST, key_in};
        end
      end
      S_WALK: begin
        if (!rd_live) begin
          ram_we    = 1'b1;
          ram_waddr = cur;
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = {EPOCH_DEAD, KEY_WIDTH'(0)};
      end
      S_ROOT: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  abst_ram #(
    .WIDTH (MW),
    .DEPTH (TABLE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      clr_root <= 1'b0;
      epoch    <= EPOCH_FIRST;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            key_q <= key_in;
            cur   <= '0;
            if (cmd.op == OP_INSERT) begin
              state <= S_WALK;
            end else if (epoch == EPOCH_LAST) begin
              state    <= S_CLEAR;
              clr_cnt  <= '0;
              clr_root <= 1'b1;
            end else begin
              epoch         <= epoch + EPOCH_FIRST;
              done          <= 1'b1;
              result.status <= ST_ROOT;
              result.slot   <= '0;
            end
          end
        end
        S_WALK: begin
          if (!rd_live) begin
            // Free slot: the key is written there; an empty root reports it as a new root.
            state         <= S_IDLE;
            done          <= 1'b1;
            result.status <= (cur == '0) ? ST_ROOT : ST_INSERTED;
            result.slot   <= cur_wide[SLOT_WIDTH-1:0];
          end else if (rd_equal) begin
            state         <= S_IDLE;
            done          <= 1'b1;
            result.status <= ST_DUPLICATE;
            result.slot   <= cur_wide[SLOT_WIDTH-1:0];
          end else if (child_out) begin
            // The bound is checked before the child is used; the parent is reported.
            state         <= S_IDLE;
            done          <= 1'b1;
            result.status <= ST_OVERFLOW;
            result.slot   <= cur_wide[SLOT_WIDTH-1:0];
          end else begin
            cur <= child[AW-1:0];
          end
        end
        S_CLEAR: begin
          if (clr_cnt == AW'(TABLE_SIZE - 1)) begin
            epoch <= EPOCH_FIRST;
            state <= clr_root ? S_ROOT : S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + AW'(1);
          end
        end
        S_ROOT: begin
          clr_root      <= 1'b0;
          state         <= S_IDLE;
          done          <= 1'b1;
          result.status <= ST_ROOT;
          result.slot   <= '0;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_insert_walks: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd.op == OP_INSERT)) |=> (state == S_WALK))
    else $error("accepted insert did not start a tree walk");

  a_no_result_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !done)
    else $error("result strobed during the clearing sweep");

  a_overflow_from_walk: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_OVERFLOW)) |-> ($past(state) == S_WALK))
    else $error("overflow reported outside a tree walk");

  a_walk_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> ({1'b0, cur} < (AW+1)'(TABLE_SIZE)))
    else $error("walk slot beyond the table");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/abst_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Stands alone; used by the tree insert unit for its key and tag store.
`timescale 1ns / 1ps
`default_nettype none

module abst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
